### design/devt_pkg.sv
// Package for the dihedral energy/virial tally block.
// Holds word structs, request and register codes, state encoding and
// saturating helpers. No dependencies.
package devt_pkg;

  localparam int MAX_ATOMS_DEF = 1024;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [2:0]         vector_slot;
    logic signed [31:0] comp_x;
    logic signed [31:0] comp_y;
    logic signed [31:0] comp_z;
    logic [9:0]         atom_first;
    logic [9:0]         atom_second;
    logic [9:0]         atom_third;
    logic [9:0]         atom_fourth;
    logic signed [31:0] energy_term;
  } in_word_t;

  typedef struct packed {
    logic signed [63:0] sum_value;
    logic               last_word;
  } out_word_t;

  typedef enum logic [2:0] {
    REQ_LOAD    = 3'd0,
    REQ_TALLY   = 3'd1,
    REQ_RD_ATOM = 3'd2,
    REQ_RD_GLOB = 3'd3,
    REQ_CLEAR   = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    CFG_ENERGY_MODE = 3'd0,
    CFG_VIRIAL_MODE = 3'd1,
    CFG_NEWTON      = 3'd2,
    CFG_LOCAL_CNT   = 3'd3,
    CFG_GHOST_CNT   = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_ATOM,
    S_GLOB,
    S_RD_ISSUE,
    S_RD_WAIT,
    S_RG,
    S_CLR
  } state_t;

  typedef struct packed {
    logic       load;
    logic       prep;
    logic       mul;
    logic [1:0] comp;
    logic [1:0] atom;
    logic [3:0] term;
  } vec_ctl_t;

  function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
    logic signed [31:0] r;
    if (x > 36'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (x < -36'sh0_8000_0000) r = -32'sh8000_0000;
    else r = x[31:0];
    return r;
  endfunction

  // virial term -> offset component, force component
  function automatic logic [1:0] term_a(input logic [3:0] t);
    logic [1:0] r;
    case (t)
      4'd0, 4'd3, 4'd4: r = 2'd0;
      4'd1, 4'd5, 4'd6: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] term_f(input logic [3:0] t);
    logic [1:0] r;
    case (t)
      4'd0, 4'd6, 4'd7: r = 2'd0;
      4'd1, 4'd3, 4'd8: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

endpackage

### design/devt_mem.sv
// Per-atom accumulator memory: one write port, one registered read port.
// Sixteen word slots per atom (energy, nine virial). Uses devt_pkg.
module devt_mem import devt_pkg::*; #(
  parameter int ADDR_W = 14
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [63:0]       wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [63:0]       rdata_r
);

  logic [63:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

### design/devt_vec.sv
// Vector file, force/offset derivation and the shared 32x32 multiplier.
// Controlled by the sequencer through vec_ctl_t. Uses devt_pkg.
module devt_vec import devt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  vec_ctl_t           ctl,
  input  logic [2:0]         slot,
  input  logic signed [31:0] ld_x,
  input  logic signed [31:0] ld_y,
  input  logic signed [31:0] ld_z,
  output logic signed [63:0] prod_r
);

  logic signed [31:0] vf_r [6][3];
  logic signed [31:0] f_r  [4][3];
  logic signed [31:0] a_r  [4][3];

  logic signed [35:0] b1, b2, b3, fs;
  logic signed [35:0] n1, n2, n3, n4;
  logic [1:0]         c;

  always_comb begin
    c  = ctl.comp;
    fs = 36'(vf_r[0][c]) + 36'(vf_r[1][c]) + 36'(vf_r[2][c]);
    b1 = 36'(vf_r[3][c]);
    b2 = 36'(vf_r[4][c]);
    b3 = 36'(vf_r[5][c]);
    n1 = 3 * b1 - 2 * b2 - b3;
    n2 = -b1 - 2 * b2 - b3;
    n3 = -b1 + 2 * b2 - b3;
    n4 = -b1 + 2 * b2 + 3 * b3;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < 6; s++) begin
        for (int k = 0; k < 3; k++) begin
          vf_r[s][k] <= '0;
        end
      end
    end else if (ctl.load && slot < 3'd6) begin
      vf_r[slot][0] <= ld_x;
      vf_r[slot][1] <= ld_y;
      vf_r[slot][2] <= ld_z;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.prep) begin
      f_r[0][c] <= vf_r[0][c];
      f_r[1][c] <= sat32(-fs);
      f_r[2][c] <= vf_r[1][c];
      f_r[3][c] <= vf_r[2][c];
      a_r[0][c] <= sat32(n1 >>> 2);
      a_r[1][c] <= sat32(n2 >>> 2);
      a_r[2][c] <= sat32(n3 >>> 2);
      a_r[3][c] <= sat32(n4 >>> 2);
    end
    if (ctl.mul) begin
      prod_r <= 64'(a_r[ctl.atom][term_a(ctl.term)]) * 64'(f_r[ctl.atom][term_f(ctl.term)]);
    end
  end

endmodule

### design/dihedral_energy_virial_tally.sv
// Top level of the dihedral energy/virial tally block.
// Uses devt_pkg, devt_vec and devt_mem.
//
// Input channel in_valid/in_ready/in_data carries one request word; results
// leave on out_valid/out_ready/out_data. Configuration is a plain write port
// (cfg_we, cfg_index, cfg_wdata), to be written only while the block is idle;
// the block itself does not enforce this. A load writes the vector file. A
// tally derives forces and offsets, then runs read-add-write over four atoms
// of ten words through the shared multiplier and the accumulator memory, then
// passes over the global sums. Read atom gives ten words, read global seven
// words, both slowed by any receiver stall, which holds the output register.
// Clear zeroes the words of each cleared atom (local count, plus ghost count
// under newton, capped at MAX_ATOMS) when per-atom tallies are on.
// Reset clears config, global sums and the vector file; per-atom memory holds
// garbage until the first clear. The last word of a read run can wait in the
// output register while the next request is accepted.
module dihedral_energy_virial_tally import devt_pkg::*; #(
  parameter int MAX_ATOMS = MAX_ATOMS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data,
  input  logic      cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [10:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_ATOMS);
  localparam int MW = AW + 4;
  localparam int CW = $clog2(MAX_ATOMS + 1);

  state_t state_r, state_nxt;

  logic [1:0]  em_r;
  logic [2:0]  vm_r;
  logic        nw_r;
  logic [10:0] lc_r, gc_r;

  in_word_t    req_r;
  logic [1:0]  k_r;
  logic [3:0]  j_r;
  logic [CW-1:0] ci_r, n_r, n_calc;
  logic [11:0] n_sum;

  logic          p_v_r, p_we_r;
  logic [3:0]    p_j_r;
  logic [MW-1:0] p_addr_r;

  logic signed [63:0] v_r [6];
  logic signed [63:0] te_r;
  logic signed [63:0] tv_r [6];

  logic      out_valid_r;
  out_word_t out_data_r;

  logic [9:0] idx [4];
  logic [3:0] loc, inr, cred;
  logic signed [63:0] eq, ef, prod_r, addend;
  logic       accept, slot_free, load_out, gen;

  vec_ctl_t   vctl;
  logic          m_we, m_re;
  logic [MW-1:0] m_waddr, m_raddr;
  logic [63:0]   m_wdata, m_rdata;
  out_word_t     out_nxt;

  devt_vec u_vec (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (vctl),
    .slot   (in_data.vector_slot),
    .ld_x   (in_data.comp_x),
    .ld_y   (in_data.comp_y),
    .ld_z   (in_data.comp_z),
    .prod_r (prod_r)
  );

  devt_mem #(.ADDR_W(MW)) u_mem (
    .clk     (clk),
    .we      (m_we),
    .waddr   (m_waddr),
    .wdata   (m_wdata),
    .re      (m_re),
    .raddr   (m_raddr),
    .rdata_r (m_rdata)
  );

  assign idx[0] = req_r.atom_first;
  assign idx[1] = req_r.atom_second;
  assign idx[2] = req_r.atom_third;
  assign idx[3] = req_r.atom_fourth;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      loc[k]  = {1'b0, idx[k]} < lc_r;
      inr[k]  = 32'(idx[k]) < MAX_ATOMS;
      cred[k] = nw_r || loc[k];
    end
  end

  assign eq = {{18{req_r.energy_term[31]}}, req_r.energy_term, 14'd0};
  assign ef = {{16{req_r.energy_term[31]}}, req_r.energy_term, 16'd0};

  assign n_sum  = {1'b0, lc_r} + (nw_r ? {1'b0, gc_r} : 12'd0);
  assign n_calc = (32'(n_sum) > MAX_ATOMS) ? CW'(MAX_ATOMS) : CW'(n_sum);

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign addend = (p_j_r == 4'd0) ? eq : prod_r;
  assign gen    = nw_r ? (k_r == 2'd0) : loc[k_r];

  always_comb begin
    state_nxt = state_r;
    vctl      = '0;
    m_re      = 1'b0;
    m_raddr   = '0;
    m_we      = p_v_r && p_we_r;
    m_waddr   = p_addr_r;
    m_wdata   = sadd64(m_rdata, addend);
    load_out  = 1'b0;
    out_nxt   = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_data.req_type)
            REQ_LOAD:    vctl.load = 1'b1;
            REQ_TALLY:   state_nxt = S_PREP;
            REQ_RD_ATOM: state_nxt = S_RD_ISSUE;
            REQ_RD_GLOB: state_nxt = S_RG;
            REQ_CLEAR: begin
              if ((em_r[1] || vm_r[2]) && n_calc != '0) state_nxt = S_CLR;
            end
            default: ;
          endcase
        end
      end
      S_PREP: begin
        vctl.prep = 1'b1;
        vctl.comp = j_r[1:0];
        if (j_r == 4'd2) state_nxt = S_ATOM;
      end
      S_ATOM: begin
        m_re    = 1'b1;
        m_raddr = {AW'(idx[k_r]), j_r};
        if (j_r != 4'd0) begin
          vctl.mul  = 1'b1;
          vctl.atom = k_r;
          vctl.term = j_r - 4'd1;
        end
        if (k_r == 2'd3 && j_r == 4'd9) state_nxt = S_GLOB;
      end
      S_GLOB: begin
        if (k_r == 2'd3 && j_r == 4'd6) state_nxt = S_IDLE;
      end
      S_RD_ISSUE: begin
        m_re      = 1'b1;
        m_raddr   = {AW'(req_r.atom_first), j_r};
        state_nxt = S_RD_WAIT;
      end
      S_RD_WAIT: begin
        if (slot_free) begin
          load_out          = 1'b1;
          out_nxt.sum_value = inr[0] ? m_rdata : 64'd0;
          out_nxt.last_word = (j_r == 4'd9);
          state_nxt         = (j_r == 4'd9) ? S_IDLE : S_RD_ISSUE;
        end
      end
      S_RG: begin
        if (slot_free) begin
          load_out          = 1'b1;
          out_nxt.sum_value = (j_r == 4'd0) ? te_r : tv_r[3'(j_r - 4'd1)];
          out_nxt.last_word = (j_r == 4'd6);
          if (j_r == 4'd6) state_nxt = S_IDLE;
        end
      end
      S_CLR: begin
        m_we    = (j_r == 4'd0) ? em_r[1] : vm_r[2];
        m_waddr = {AW'(ci_r), j_r};
        m_wdata = '0;
        if (CW'(ci_r + 1'b1) == n_r && j_r == 4'd9) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // config, global sums, output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_r        <= '0;
      vm_r        <= '0;
      nw_r        <= 1'b0;
      lc_r        <= '0;
      gc_r        <= '0;
      te_r        <= '0;
      for (int c = 0; c < 6; c++) tv_r[c] <= '0;
      out_valid_r <= 1'b0;
      p_v_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ENERGY_MODE: em_r <= cfg_wdata[1:0];
          CFG_VIRIAL_MODE: vm_r <= cfg_wdata[2:0];
          CFG_NEWTON:      nw_r <= cfg_wdata[0];
          CFG_LOCAL_CNT:   lc_r <= cfg_wdata;
          CFG_GHOST_CNT:   gc_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept && in_data.req_type == REQ_CLEAR) begin
        if (em_r[0]) te_r <= '0;
        if (vm_r[1:0] != 2'd0) for (int c = 0; c < 6; c++) tv_r[c] <= '0;
      end
      if (state_r == S_GLOB && gen) begin
        if (j_r == 4'd0) begin
          if (em_r[0]) te_r <= sadd64(te_r, nw_r ? ef : eq);
        end else if (vm_r[1:0] != 2'd0) begin
          tv_r[3'(j_r - 4'd1)] <= sadd64(tv_r[3'(j_r - 4'd1)],
                                         nw_r ? v_r[3'(j_r - 4'd1)]
                                              : (v_r[3'(j_r - 4'd1)] >>> 2));
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      p_v_r <= (state_r == S_ATOM);
    end
  end

  // request, counters, pipeline tag, virial sums
  always_ff @(posedge clk) begin
    if (load_out) out_data_r <= out_nxt;
    p_j_r    <= j_r;
    p_addr_r <= m_raddr;
    p_we_r   <= cred[k_r] && inr[k_r] && ((j_r == 4'd0) ? em_r[1] : vm_r[2]);
    if (p_v_r && p_j_r != 4'd0 && p_j_r < 4'd7) begin
      v_r[3'(p_j_r - 4'd1)] <= sadd64(v_r[3'(p_j_r - 4'd1)], prod_r);
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_r <= in_data;
          k_r   <= '0;
          j_r   <= '0;
          ci_r  <= '0;
          n_r   <= n_calc;
          for (int c = 0; c < 6; c++) v_r[c] <= '0;
        end
      end
      S_PREP: j_r <= (j_r == 4'd2) ? 4'd0 : j_r + 4'd1;
      S_ATOM: begin
        if (j_r == 4'd9) begin
          j_r <= '0;
          k_r <= k_r + 2'd1;
        end else begin
          j_r <= j_r + 4'd1;
        end
      end
      S_GLOB: begin
        if (j_r == 4'd6) begin
          j_r <= '0;
          k_r <= k_r + 2'd1;
        end else begin
          j_r <= j_r + 4'd1;
        end
      end
      S_RD_WAIT, S_RG: begin
        if (load_out) j_r <= j_r + 4'd1;
      end
      S_CLR: begin
        if (j_r == 4'd9) begin
          j_r  <= '0;
          ci_r <= ci_r + 1'b1;
        end else begin
          j_r <= j_r + 4'd1;
        end
      end
      default: ;
    endcase
  end

endmodule
